// ===== rtl/core/ppg_adaptive_peak_detector_macros.svh =====
// ----------------------------------------------------------------------------
// ppg peak detector assertion macros
// shared property forms for the checker; clk and rst come from the user
// ----------------------------------------------------------------------------
`ifndef PPG_ADAPTIVE_PEAK_DETECTOR_MACROS_SVH
`define PPG_ADAPTIVE_PEAK_DETECTOR_MACROS_SVH

// consequent must hold in the same cycle
`define PPG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppg peak detector check failed");

// consequent must hold in the following cycle
`define PPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppg peak detector check failed");

`endif

// ===== rtl/core/ppg_apd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppg_apd_pkg
// types and constants shared by the adaptive peak detector modules
// ----------------------------------------------------------------------------
package ppg_apd_pkg;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // fixed field widths
  localparam int unsigned CAL_W   = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned GAP_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAL_COUNT = 3'd0,
    REG_THR_PCT   = 3'd1,
    REG_DECAY_PCT = 3'd2,
    REG_MIN_GAP   = 3'd3,
    REG_MAX_GAP   = 3'd4
  } reg_idx_t;

  // reset values of the registers
  localparam logic [CAL_W-1:0] RESET_CAL_COUNT = 8'd50;
  localparam logic [PCT_W-1:0] RESET_THR_PCT   = 7'd60;
  localparam logic [PCT_W-1:0] RESET_DECAY_PCT = 7'd95;
  localparam logic [GAP_W-1:0] RESET_MIN_GAP   = 16'd300;
  localparam logic [GAP_W-1:0] RESET_MAX_GAP   = 16'd2000;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CAL_W-1:0] cal_count;
    logic [PCT_W-1:0] thr_pct;
    logic [PCT_W-1:0] decay_pct;
    logic [GAP_W-1:0] min_gap;
    logic [GAP_W-1:0] max_gap;
  } cfg_t;

  // sample class worked out by the front
  typedef struct packed {
    logic calib;
    logic calib_end;
    logic rising;
  } cls_t;

  localparam int unsigned CLS_W = $bits(cls_t);

endpackage

// ===== rtl/core/ppg_apd_scale.sv =====
// ----------------------------------------------------------------------------
// ppg_apd_scale
// percentage scaling of a non-negative sample, saturating at full scale
// ----------------------------------------------------------------------------
module ppg_apd_scale #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned SHIFT       = 37
) (
  input  logic [SAMPLE_BITS-2:0] value,
  input  logic [SHIFT:0]         mult,
  output logic [SAMPLE_BITS-2:0] result
);

  logic [SAMPLE_BITS+SHIFT-1:0] prod;
  logic [SAMPLE_BITS-1:0]       quot;

  // mult holds percent times the reciprocal of one hundred
  assign prod = (SAMPLE_BITS+SHIFT)'(value) * (SAMPLE_BITS+SHIFT)'(mult);
  assign quot = prod[SAMPLE_BITS+SHIFT-1:SHIFT];

  // clip to the largest positive sample
  assign result = quot[SAMPLE_BITS-1] ? '1 : quot[SAMPLE_BITS-2:0];

endmodule

// ===== rtl/core/ppg_apd_cfg.sv =====
// ----------------------------------------------------------------------------
// ppg_apd_cfg
// configuration registers and the scaled percentage factors
// ----------------------------------------------------------------------------
module ppg_apd_cfg #(
  parameter int unsigned SHIFT = 37
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppg_apd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppg_apd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ppg_apd_pkg::cfg_t                  cfg,
  output logic [SHIFT:0]                     thr_mult,
  output logic [SHIFT:0]                     decay_mult
);

  import ppg_apd_pkg::*;

  // ceiling of 2^SHIFT / 100, exact for every product that can occur
  localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'd99) / 64'd100;
  localparam logic [SHIFT-7:0] RECIP = RECIP64[SHIFT-7:0];

  logic write;

  assign cfg_ready = 1'b1;
  assign write     = cfg_valid & cfg_ready;

  // register file, factors follow the percent writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_count <= RESET_CAL_COUNT;
      cfg.thr_pct   <= RESET_THR_PCT;
      cfg.decay_pct <= RESET_DECAY_PCT;
      cfg.min_gap   <= RESET_MIN_GAP;
      cfg.max_gap   <= RESET_MAX_GAP;
      thr_mult      <= (SHIFT+1)'(RESET_THR_PCT) * (SHIFT+1)'(RECIP);
      decay_mult    <= (SHIFT+1)'(RESET_DECAY_PCT) * (SHIFT+1)'(RECIP);
    end else if (write) begin
      unique case (cfg_index)
        REG_CAL_COUNT: cfg.cal_count <= cfg_data[CAL_W-1:0];
        REG_THR_PCT: begin
          cfg.thr_pct <= cfg_data[PCT_W-1:0];
          thr_mult    <= (SHIFT+1)'(cfg_data[PCT_W-1:0]) * (SHIFT+1)'(RECIP);
        end
        REG_DECAY_PCT: begin
          cfg.decay_pct <= cfg_data[PCT_W-1:0];
          decay_mult    <= (SHIFT+1)'(cfg_data[PCT_W-1:0]) * (SHIFT+1)'(RECIP);
        end
        REG_MIN_GAP: cfg.min_gap <= cfg_data[GAP_W-1:0];
        REG_MAX_GAP: cfg.max_gap <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ppg_apd_queue.sv =====
// ----------------------------------------------------------------------------
// ppg_apd_queue
// short first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module ppg_apd_queue #(
  parameter int unsigned WIDTH = 138
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  import ppg_apd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ppg_apd_front.sv =====
// ----------------------------------------------------------------------------
// ppg_apd_front
// takes samples, counts them, tracks the maximum and classifies each one
// ----------------------------------------------------------------------------
module ppg_apd_front #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned SHIFT       = 37,
  parameter int unsigned ENTRY_W     = 138
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     sample_value,
  input  logic [ppg_apd_pkg::TIME_W-1:0]    time_ms,
  input  ppg_apd_pkg::cfg_t                 cfg,
  input  logic [SHIFT:0]                    thr_mult,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [ENTRY_W-1:0]                q_din
);

  import ppg_apd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic [COUNT_W-1:0]            count;

  logic signed [SAMPLE_BITS-1:0] run_max_next;
  logic [COUNT_W-1:0]            count_next;
  logic [SAMPLE_BITS-2:0]        pos_sample;
  logic [SAMPLE_BITS-2:0]        sample_scaled;
  logic [SAMPLE_BITS-2:0]        max_scaled;
  cls_t                          cls;

  assign in_ready = !q_full;
  assign q_push   = in_valid & in_ready;

  // running maximum and saturating sample count
  assign run_max_next = (sample_value > run_max) ? sample_value : run_max;
  assign count_next   = (count == COUNT_MAX) ? COUNT_MAX : count + 1'b1;

  // classification of this request
  assign cls.calib     = (count_next <= COUNT_W'(cfg.cal_count));
  assign cls.calib_end = (count_next == COUNT_W'(cfg.cal_count));
  assign cls.rising    = (sample_value > prev);

  // negative samples never reach the scaled path
  assign pos_sample = sample_value[SAMPLE_BITS-1] ? '0 : sample_value[SAMPLE_BITS-2:0];

  ppg_apd_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SHIFT       (SHIFT)
  ) u_scale_sample (
    .value  (pos_sample),
    .mult   (thr_mult),
    .result (sample_scaled)
  );

  // running maximum is never negative
  ppg_apd_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SHIFT       (SHIFT)
  ) u_scale_max (
    .value  (run_max_next[SAMPLE_BITS-2:0]),
    .mult   (thr_mult),
    .result (max_scaled)
  );

  assign q_din = {cls, sample_value, time_ms, sample_scaled, max_scaled};

  // front state follows every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      prev    <= '0;
      run_max <= '0;
      count   <= '0;
    end else if (q_push) begin
      prev    <= sample_value;
      run_max <= run_max_next;
      count   <= count_next;
    end
  end

endmodule

// ===== rtl/core/ppg_apd_back.sv =====
// ----------------------------------------------------------------------------
// ppg_apd_back
// threshold tracking, candidate handling and beat decision per queued sample
// ----------------------------------------------------------------------------
module ppg_apd_back #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned SHIFT       = 37,
  parameter int unsigned ENTRY_W     = 138
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ppg_apd_pkg::cfg_t              cfg,
  input  logic [SHIFT:0]                 decay_mult,
  input  logic                           q_empty,
  input  logic [ENTRY_W-1:0]             q_dout,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           beat_found,
  output logic                           interval_valid,
  output logic [ppg_apd_pkg::GAP_W-1:0]  interval_ms,
  output logic signed [SAMPLE_BITS-1:0]  beat_amplitude
);

  import ppg_apd_pkg::*;

  localparam logic [SAMPLE_BITS-2:0] THR_ONE = (SAMPLE_BITS-1)'(1);

  // queue entry fields
  cls_t                          e_cls;
  logic signed [SAMPLE_BITS-1:0] e_sample;
  logic [TIME_W-1:0]             e_time;
  logic [SAMPLE_BITS-2:0]        e_sample_scaled;
  logic [SAMPLE_BITS-2:0]        e_max_scaled;

  // detector state
  logic [SAMPLE_BITS-2:0]        thr;
  logic                          rose_last;
  logic signed [SAMPLE_BITS-1:0] cand_value;
  logic [TIME_W-1:0]             cand_time;
  logic                          cand_held;
  logic [TIME_W-1:0]             last_beat;

  logic [SAMPLE_BITS-2:0]        thr_next;
  logic                          rose_last_next;
  logic signed [SAMPLE_BITS-1:0] cand_value_next;
  logic [TIME_W-1:0]             cand_time_next;
  logic                          cand_held_next;
  logic [TIME_W-1:0]             last_beat_next;

  logic                          beat_next;
  logic                          ivalid_next;
  logic [GAP_W-1:0]              ival_next;
  logic signed [SAMPLE_BITS-1:0] amp_next;

  logic [SAMPLE_BITS-2:0]        decayed;
  logic [SAMPLE_BITS-2:0]        decayed_floor;
  logic [SAMPLE_BITS-2:0]        detect_thr;
  logic [TIME_W-1:0]             gap;

  assign {e_cls, e_sample, e_time, e_sample_scaled, e_max_scaled} = q_dout;

  assign q_pop = !q_empty && (!out_valid || out_ready);

  // threshold decay
  ppg_apd_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SHIFT       (SHIFT)
  ) u_scale_decay (
    .value  (thr),
    .mult   (decay_mult),
    .result (decayed)
  );

  assign decayed_floor = (decayed == '0) ? THR_ONE : decayed;
  assign detect_thr    = (e_sample > $signed({1'b0, decayed_floor})) ? e_sample_scaled
                                                                      : decayed_floor;
  assign gap           = e_time - last_beat;

  // next state and result of the queued sample
  always_comb begin
    thr_next        = thr;
    rose_last_next  = rose_last;
    cand_value_next = cand_value;
    cand_time_next  = cand_time;
    cand_held_next  = cand_held;
    last_beat_next  = last_beat;
    beat_next       = 1'b0;
    ivalid_next     = 1'b0;
    ival_next       = '0;
    amp_next        = '0;
    if (e_cls.calib) begin
      rose_last_next  = 1'b0;
      cand_value_next = '0;
      cand_time_next  = '0;
      cand_held_next  = 1'b0;
      if (e_cls.calib_end) begin
        thr_next = (e_max_scaled == '0) ? THR_ONE : e_max_scaled;
      end
    end else begin
      thr_next       = detect_thr;
      rose_last_next = e_cls.rising;
      if (e_cls.rising) begin
        if (e_sample > $signed({1'b0, detect_thr})) begin
          cand_value_next = e_sample;
          cand_time_next  = e_time;
          cand_held_next  = 1'b1;
        end
      end else if (rose_last && cand_held) begin
        cand_held_next = 1'b0;
        if ((cand_value > $signed({1'b0, detect_thr})) &&
            (gap >= TIME_W'(cfg.min_gap))) begin
          beat_next      = 1'b1;
          amp_next       = cand_value;
          last_beat_next = cand_time;
          if ((last_beat != '0) && (gap <= TIME_W'(cfg.max_gap))) begin
            ivalid_next = 1'b1;
            ival_next   = gap[GAP_W-1:0];
          end
        end
      end
    end
  end

  // detector state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= '0;
      rose_last  <= 1'b0;
      cand_value <= '0;
      cand_time  <= '0;
      cand_held  <= 1'b0;
      last_beat  <= '0;
    end else if (q_pop) begin
      thr        <= thr_next;
      rose_last  <= rose_last_next;
      cand_value <= cand_value_next;
      cand_time  <= cand_time_next;
      cand_held  <= cand_held_next;
      last_beat  <= last_beat_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      beat_found     <= beat_next;
      interval_valid <= ivalid_next;
      interval_ms    <= ival_next;
      beat_amplitude <= amp_next;
    end
  end

endmodule

// ===== rtl/core/ppg_adaptive_peak_detector.sv =====
// ----------------------------------------------------------------------------
// ppg_adaptive_peak_detector
// adaptive threshold local maximum peak detector for filtered ppg samples
// ----------------------------------------------------------------------------
// One result per sample. A sample is taken every cycle while the two-entry
// queue between front and back has room; its entry is written into the queue,
// then popped and its result loaded into the output register whenever that
// register is free, so the block sustains one sample per clock while the
// receiver takes every result. The front counts samples, tracks the maximum
// and precomputes the percentage of the sample and of the maximum; the back
// runs the threshold recurrence, whose combinational path (decay multiply,
// floor, compare, select) fixes the rate. The output register holds a result
// under back pressure while the queue keeps taking samples. Configuration writes are accepted in every cycle.
module ppg_adaptive_peak_detector #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppg_apd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppg_apd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      sample_value,
  input  logic [ppg_apd_pkg::TIME_W-1:0]     time_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               beat_found,
  output logic                               interval_valid,
  output logic [ppg_apd_pkg::GAP_W-1:0]      interval_ms,
  output logic signed [SAMPLE_BITS-1:0]      beat_amplitude
);

  import ppg_apd_pkg::*;

  // reciprocal shift wide enough for exact division by one hundred
  localparam int unsigned SHIFT   = SAMPLE_BITS + 13;
  localparam int unsigned ENTRY_W = CLS_W + SAMPLE_BITS + TIME_W + 2 * (SAMPLE_BITS - 1);

  cfg_t               cfg;
  logic [SHIFT:0]     thr_mult;
  logic [SHIFT:0]     decay_mult;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_din;
  logic [ENTRY_W-1:0] q_dout;

  ppg_apd_cfg #(
    .SHIFT (SHIFT)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .thr_mult   (thr_mult),
    .decay_mult (decay_mult)
  );

  ppg_apd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SHIFT       (SHIFT),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .time_ms      (time_ms),
    .cfg          (cfg),
    .thr_mult     (thr_mult),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_din        (q_din)
  );

  ppg_apd_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  ppg_apd_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SHIFT       (SHIFT),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .decay_mult     (decay_mult),
    .q_empty        (q_empty),
    .q_dout         (q_dout),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .beat_found     (beat_found),
    .interval_valid (interval_valid),
    .interval_ms    (interval_ms),
    .beat_amplitude (beat_amplitude)
  );

endmodule

// ===== rtl/core/ppg_apd_chk.sv =====
// ----------------------------------------------------------------------------
// ppg_apd_chk
// port level checks on the peak detector, bound to the top level
// ----------------------------------------------------------------------------
`include "ppg_adaptive_peak_detector_macros.svh"

module ppg_apd_chk #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               beat_found,
  input  logic                               interval_valid,
  input  logic [ppg_apd_pkg::GAP_W-1:0]      interval_ms,
  input  logic signed [SAMPLE_BITS-1:0]      beat_amplitude
);

  // an interval only comes with a beat
  `PPG_ASSERT_SAME(a_interval_needs_beat, out_valid && interval_valid, beat_found)

  // a sample without a beat reports zero fields
  `PPG_ASSERT_SAME(a_quiet_fields_zero, out_valid && !beat_found, (interval_ms == '0) && (beat_amplitude == '0) && !interval_valid)

  // configuration writes never stall
  `PPG_ASSERT_SAME(a_cfg_never_stalls, cfg_valid, cfg_ready)

  // a stalled result holds
  `PPG_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(beat_found) && $stable(interval_ms) && $stable(beat_amplitude))

endmodule

bind ppg_adaptive_peak_detector ppg_apd_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ppg_apd_chk (.*);

// ===== test/ppg_adaptive_peak_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_adaptive_peak_detector_test
// self-checking bench for the adaptive peak detector: a short directed table,
// then random pulse trains with noise, each result checked in order against
// a cycle-free model of the threshold and beat logic
// ----------------------------------------------------------------------------
module ppg_adaptive_peak_detector_test;
  import ppg_apd_pkg::*;

  localparam int unsigned SBITS = 24;
  localparam longint SAMPLE_TOP = (longint'(1) << (SBITS - 1)) - 1;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned PHASES = 8;

  typedef struct packed {
    logic             beat;
    logic             ivalid;
    logic [GAP_W-1:0] ival;
    logic [SBITS-1:0] amp;
  } beat_report_t;

  typedef enum logic {ROW_SETUP, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    cfg_t                    setup;
    logic signed [SBITS-1:0] s;
    logic [TIME_W-1:0]       t;
    bit                      zero_known;
  } stim_row_t;

  // block ports
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  reg_idx_t                cfg_index = REG_CAL_COUNT;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [SBITS-1:0] sample_value = '0;
  logic [TIME_W-1:0]       time_ms = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    beat_found;
  logic                    interval_valid;
  logic [GAP_W-1:0]        interval_ms;
  logic signed [SBITS-1:0] beat_amplitude;

  // bench state
  bit                steady = 1'b0;
  int unsigned       mismatches = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  beat_report_t      detector_reports[$];

  // predictor copy of the registers and detector state
  cfg_t regs_model = '{RESET_CAL_COUNT, RESET_THR_PCT, RESET_DECAY_PCT,
                       RESET_MIN_GAP, RESET_MAX_GAP};
  int unsigned       counted = 0;
  longint            peak_max = 0;
  longint            thr_level = 0;
  longint            prev_s = 0;
  longint            cand_val = 0;
  bit                rose = 1'b0;
  bit                cand_held = 1'b0;
  logic [TIME_W-1:0] cand_t = '0;
  logic [TIME_W-1:0] last_beat_t = '0;

  ppg_adaptive_peak_detector #(
    .SAMPLE_BITS(SBITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_value(sample_value),
    .time_ms(time_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .beat_found(beat_found),
    .interval_valid(interval_valid),
    .interval_ms(interval_ms),
    .beat_amplitude(beat_amplitude)
  );

  // percentage of a nonnegative value, clipped to the largest sample
  function automatic longint pct_of(longint v, logic [PCT_W-1:0] p);
    longint r;
    r = (v * longint'(p)) / 100;
    return (r > SAMPLE_TOP) ? SAMPLE_TOP : r;
  endfunction

  // one sample through the threshold and beat logic
  function automatic beat_report_t detect_step(longint s, logic [TIME_W-1:0] t);
    beat_report_t      r;
    bit                up;
    logic [TIME_W-1:0] gap;
    r = '0;
    if (s > peak_max) peak_max = s;
    if (counted < COUNT_MAX) counted++;
    if (counted <= regs_model.cal_count) begin
      // calibration: only the maximum is tracked, and the threshold is set at its end
      prev_s = s;
      rose = 1'b0;
      cand_val = 0;
      cand_t = '0;
      cand_held = 1'b0;
      if (counted == regs_model.cal_count) begin
        thr_level = pct_of(peak_max, regs_model.thr_pct);
        if (thr_level < 1) thr_level = 1;
      end
    end else begin
      // decay, floor, then set from the percentage of a sample above the threshold
      thr_level = pct_of(thr_level, regs_model.decay_pct);
      if (thr_level < 1) thr_level = 1;
      if (s > thr_level) thr_level = pct_of(s, regs_model.thr_pct);
      up = s > prev_s;
      if (up) begin
        if (s > thr_level) begin
          cand_val = s;
          cand_t = t;
          cand_held = 1'b1;
        end
      end else if (rose && cand_held) begin
        // first falling sample after a rise: confirm or drop the candidate
        gap = t - last_beat_t;
        if (cand_val > thr_level && gap >= regs_model.min_gap) begin
          r.beat = 1'b1;
          r.amp = cand_val[SBITS-1:0];
          if (last_beat_t != 0 && gap <= regs_model.max_gap) begin
            r.ivalid = 1'b1;
            r.ival = gap[GAP_W-1:0];
          end
          last_beat_t = cand_t;
        end
        cand_held = 1'b0;
      end
      prev_s = s;
      rose = up;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic stim_row_t setup_row(logic [CAL_W-1:0] cal, logic [PCT_W-1:0] thr,
                                          logic [PCT_W-1:0] decay, logic [GAP_W-1:0] mn,
                                          logic [GAP_W-1:0] mx);
    stim_row_t r;
    r.kind = ROW_SETUP;
    r.setup = '{cal, thr, decay, mn, mx};
    r.s = '0;
    r.t = '0;
    r.zero_known = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t sample_row(logic signed [SBITS-1:0] s, logic [TIME_W-1:0] t,
                                           bit zero_known);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.setup = '0;
    r.s = s;
    r.t = t;
    r.zero_known = zero_known;
    return r;
  endfunction

  function automatic logic [PCT_W-1:0] pick_pct(int unsigned lo, int unsigned hi);
    case ($urandom_range(7))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'd127;
      default: return PCT_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [GAP_W-1:0] pick_gap(int unsigned lo, int unsigned hi);
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return GAP_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic cfg_t pick_setup();
    cfg_t c;
    case ($urandom_range(7))
      0: c.cal_count = 8'd1;
      1: c.cal_count = 8'd255;
      default: c.cal_count = CAL_W'($urandom_range(255, 1));
    endcase
    c.thr_pct = pick_pct(30, 90);
    c.decay_pct = pick_pct(80, 99);
    c.min_gap = pick_gap(50, 600);
    c.max_gap = pick_gap(300, 3000);
    return c;
  endfunction

  // one sample request, with a random gap in front of it
  task automatic send_sample(logic signed [SBITS-1:0] s, logic [TIME_W-1:0] t,
                             bit zero_known);
    beat_report_t predicted;
    if (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_valid <= 1'b1;
    sample_value <= s;
    time_ms <= t;
    do @(posedge clk); while (!in_ready);
    predicted = detect_step(longint'(s), t);
    detector_reports.push_back(zero_known ? beat_report_t'('0) : predicted);
  endtask

  // let every result drain, then write all five registers
  task automatic configure(cfg_t c);
    reg_idx_t              idx;
    logic [CFG_DATA_W-1:0] v;
    in_valid <= 1'b0;
    while (detector_reports.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    for (int i = 0; i <= int'(REG_MAX_GAP); i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_CAL_COUNT: v = CFG_DATA_W'(c.cal_count);
        REG_THR_PCT:   v = CFG_DATA_W'(c.thr_pct);
        REG_DECAY_PCT: v = CFG_DATA_W'(c.decay_pct);
        REG_MIN_GAP:   v = c.min_gap;
        default:       v = c.max_gap;
      endcase
      cfg_index <= idx;
      cfg_data <= v;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    regs_model = c;
  endtask

  // pulse trains with random shape and timing, broken up by noise
  task automatic run_phase(int unsigned n_items);
    longint      top;
    longint      peak;
    longint      base;
    longint      s;
    int          rise_n;
    int          fall_n;
    int unsigned step_lo;
    int unsigned step_hi;
    int unsigned sent;
    top = (longint'(1) << $urandom_range(SBITS - 1, 6)) - 1;
    step_lo = $urandom_range(20, 1);
    step_hi = step_lo + $urandom_range(80);
    if ($urandom_range(3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        // noise sample, sometimes with a jump in time
        if ($urandom_range(3) == 0) clock_ms = $urandom();
        else clock_ms += $urandom_range(step_hi);
        send_sample(SBITS'($urandom()), clock_ms, 1'b0);
        sent++;
      end else begin
        peak = (top * longint'($urandom_range(100, 40))) / 100;
        base = -((top * longint'($urandom_range(30))) / 100);
        rise_n = $urandom_range(6, 1);
        fall_n = $urandom_range(6, 1);
        for (int i = 1; i <= rise_n + fall_n; i++) begin
          if (i <= rise_n) s = base + (peak - base) * i / rise_n;
          else s = peak - (peak - base) * (i - rise_n) / fall_n;
          clock_ms += $urandom_range(step_hi, step_lo);
          send_sample(s[SBITS-1:0], clock_ms, 1'b0);
        end
        sent += rise_n + fall_n;
      end
    end
  endtask

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 34);
  end

  // result checker
  always @(posedge clk) begin
    beat_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (detector_reports.size() == 0) begin
        $display("%0t: result with no sample outstanding, beat_found %0b",
                 $time, beat_found);
        mismatches++;
      end else begin
        want = detector_reports.pop_front();
        check_field("beat_found", want.beat, beat_found);
        check_field("interval_valid", want.ivalid, interval_valid);
        check_field("interval_ms", want.ival, interval_ms);
        check_field("beat_amplitude", $signed(want.amp), beat_amplitude);
      end
    end
  end

  // run limit
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t dir_rows[$];
    cfg_t      fixed;

    // calibration right after reset: nothing can be reported
    dir_rows.push_back(sample_row(24'sh800000, 32'd0, 1'b1));
    dir_rows.push_back(sample_row(24'sh7FFFFF, 32'hFFFF_FFFF, 1'b1));
    // calibration count zero: detection from a threshold of zero
    dir_rows.push_back(setup_row(8'd0, 7'd50, 7'd50, 16'd0, 16'hFFFF));
    dir_rows.push_back(sample_row(24'sd0, 32'd0, 1'b0));
    dir_rows.push_back(sample_row(24'sd1000, 32'd5, 1'b0));
    // first beat: no earlier beat, so no interval
    dir_rows.push_back(sample_row(24'sd900, 32'd10, 1'b0));
    dir_rows.push_back(sample_row(24'sd2000, 32'd20, 1'b0));
    dir_rows.push_back(sample_row(24'sd1500, 32'd30, 1'b0));
    // gap up to the top of the time range, far beyond the largest interval
    dir_rows.push_back(sample_row(24'sh7FFFFF, 32'd40, 1'b0));
    dir_rows.push_back(sample_row(24'sh800000, 32'hFFFF_FFFF, 1'b0));
    // percentages above 100 saturate; refractory gap at its widest
    dir_rows.push_back(setup_row(8'd0, 7'd127, 7'd127, 16'hFFFF, 16'd0));
    dir_rows.push_back(sample_row(24'sh7FFFFF, 32'd50, 1'b0));
    dir_rows.push_back(sample_row(-24'sd5, 32'd60, 1'b0));
    dir_rows.push_back(sample_row(24'sd4000, 32'd70, 1'b0));
    dir_rows.push_back(sample_row(24'sd100, 32'd80, 1'b0));
    // zero percentages: threshold decays to its floor, and a sample above it sets it to zero
    dir_rows.push_back(setup_row(8'd0, 7'd0, 7'd0, 16'd10, 16'd0));
    dir_rows.push_back(sample_row(24'sd10, 32'd100, 1'b0));
    dir_rows.push_back(sample_row(24'sd50, 32'd110, 1'b0));
    dir_rows.push_back(sample_row(24'sd20, 32'd120, 1'b0));
    // raised calibration count puts the detector back into calibration
    dir_rows.push_back(setup_row(8'd40, 7'd60, 7'd95, 16'd300, 16'd2000));
    dir_rows.push_back(sample_row(24'sd7, 32'd200, 1'b1));
    dir_rows.push_back(sample_row(-24'sd7, 32'd210, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SETUP) configure(dir_rows[i].setup);
      else send_sample(dir_rows[i].s, dir_rows[i].t, dir_rows[i].zero_known);
    end

    // random phases, one without any stalls
    for (int p = 0; p < PHASES; p++) begin
      if (p == 5) begin
        fixed = '{8'd255, 7'd1, 7'd100, 16'd0, 16'hFFFF};
        configure(fixed);
      end else if (p != 0) begin
        configure(pick_setup());
      end
      steady = (p == 3);
      run_phase(RANDOM_ITEMS / PHASES);
    end
    steady = 1'b0;

    // drain and settle
    in_valid <= 1'b0;
    while (detector_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ppg_apd_pkg.sv
rtl/core/ppg_apd_scale.sv
rtl/core/ppg_apd_cfg.sv
rtl/core/ppg_apd_queue.sv
rtl/core/ppg_apd_front.sv
rtl/core/ppg_apd_back.sv
rtl/core/ppg_adaptive_peak_detector.sv
rtl/core/ppg_apd_chk.sv
test/ppg_adaptive_peak_detector_test.sv
